[sv/two_pool_page_allocator_top_macros.svh]
// Assertion macros shared by the page allocator RTL.
`ifndef TWO_POOL_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define TWO_POOL_PAGE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define TPPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page allocator: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define TPPA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page allocator: next-cycle check failed");

`endif

[sv/tppa_pkg.sv]
// Types, constants and microcode table of the two-pool page allocator.
`default_nettype none

package tppa_pkg;

    localparam int unsigned PAGE_STACK_DEPTH_DEF  = 32768;
    localparam int unsigned SUPER_STACK_DEPTH_DEF = 64;

    localparam int ADDR_W        = 32;
    localparam int PAGE_SHIFT    = 12;   // 4 KiB pages
    localparam int SUPER_SHIFT   = 21;   // 2 MiB superpages
    localparam int RESERVE_SHIFT = 2;    // a quarter of free memory
    localparam int PN_W          = ADDR_W - PAGE_SHIFT;
    localparam int SN_W          = ADDR_W - SUPER_SHIFT;
    localparam int REQ_W         = 3;
    localparam int STAT_W        = 2;
    localparam int TDATA_OUT_W   = 40;

    localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h8020_0000;
    localparam logic [ADDR_W-1:0] PHYS_STOP_RST  = 32'h8800_0000;

    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_req REQ_INIT       = 3'd0;
    localparam t_req REQ_ALLOC_PAGE = 3'd1;
    localparam t_req REQ_FREE_PAGE  = 3'd2;
    localparam t_req REQ_ALLOC_SUP  = 3'd3;
    localparam t_req REQ_FREE_SUP   = 3'd4;

    localparam t_status STAT_OK       = 2'd0;
    localparam t_status STAT_EMPTY    = 2'd1;
    localparam t_status STAT_BADFREE  = 2'd2;
    localparam t_status STAT_OVERFLOW = 2'd3;

    // Datapath actions, one per control word.
    typedef enum logic [3:0] {
        A_IDLE, A_POP_P, A_EMIT_P, A_POP_S, A_EMIT_S, A_FREE_P, A_FREE_S,
        A_INIT_A, A_INIT_B, A_INIT_C, A_INIT_D, A_PUSH_P, A_SET_SUP,
        A_PUSH_S, A_SET_HI, A_EMIT_ST
    } t_act;

    // Sequencing: next step, jump, jump on flag, hold until flag, dispatch.
    typedef enum logic [2:0] {
        C_NEXT, C_GOTO, C_IF, C_LOOP, C_DISPATCH
    } t_cond;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE    = 5'd0;
    localparam t_step ST_P_POP   = 5'd1;
    localparam t_step ST_P_EMIT  = 5'd2;
    localparam t_step ST_S_POP   = 5'd3;
    localparam t_step ST_S_EMIT  = 5'd4;
    localparam t_step ST_P_FREE  = 5'd5;
    localparam t_step ST_S_FREE  = 5'd6;
    localparam t_step ST_INIT_A  = 5'd7;
    localparam t_step ST_INIT_B  = 5'd8;
    localparam t_step ST_INIT_C  = 5'd9;
    localparam t_step ST_INIT_D  = 5'd10;
    localparam t_step ST_RUN_LO  = 5'd11;
    localparam t_step ST_SET_SUP = 5'd12;
    localparam t_step ST_RUN_SUP = 5'd13;
    localparam t_step ST_SET_HI  = 5'd14;
    localparam t_step ST_RUN_HI  = 5'd15;
    localparam t_step ST_EMIT_ST = 5'd16;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        logic  emit;     // step loads the result register
        t_step target;
    } t_uword;

    // What the sequencer hands to the datapath each cycle.
    typedef struct packed {
        t_act act;
        logic go;        // step executes this cycle
    } t_uctl;

    function automatic t_uword ucode(input t_step step);
        t_uword uw;
        unique case (step)
            ST_IDLE:    uw = '{act: A_IDLE,    cond: C_DISPATCH, emit: 1'b0, target: ST_IDLE};
            ST_P_POP:   uw = '{act: A_POP_P,   cond: C_IF,       emit: 1'b0, target: ST_EMIT_ST};
            ST_P_EMIT:  uw = '{act: A_EMIT_P,  cond: C_GOTO,     emit: 1'b1, target: ST_IDLE};
            ST_S_POP:   uw = '{act: A_POP_S,   cond: C_IF,       emit: 1'b0, target: ST_EMIT_ST};
            ST_S_EMIT:  uw = '{act: A_EMIT_S,  cond: C_GOTO,     emit: 1'b1, target: ST_IDLE};
            ST_P_FREE:  uw = '{act: A_FREE_P,  cond: C_GOTO,     emit: 1'b1, target: ST_IDLE};
            ST_S_FREE:  uw = '{act: A_FREE_S,  cond: C_GOTO,     emit: 1'b1, target: ST_IDLE};
            ST_INIT_A:  uw = '{act: A_INIT_A,  cond: C_NEXT,     emit: 1'b0, target: ST_IDLE};
            ST_INIT_B:  uw = '{act: A_INIT_B,  cond: C_IF,       emit: 1'b0, target: ST_EMIT_ST};
            ST_INIT_C:  uw = '{act: A_INIT_C,  cond: C_NEXT,     emit: 1'b0, target: ST_IDLE};
            ST_INIT_D:  uw = '{act: A_INIT_D,  cond: C_IF,       emit: 1'b0, target: ST_RUN_HI};
            ST_RUN_LO:  uw = '{act: A_PUSH_P,  cond: C_LOOP,     emit: 1'b0, target: ST_IDLE};
            ST_SET_SUP: uw = '{act: A_SET_SUP, cond: C_NEXT,     emit: 1'b0, target: ST_IDLE};
            ST_RUN_SUP: uw = '{act: A_PUSH_S,  cond: C_LOOP,     emit: 1'b0, target: ST_IDLE};
            ST_SET_HI:  uw = '{act: A_SET_HI,  cond: C_NEXT,     emit: 1'b0, target: ST_IDLE};
            ST_RUN_HI:  uw = '{act: A_PUSH_P,  cond: C_LOOP,     emit: 1'b0, target: ST_IDLE};
            ST_EMIT_ST: uw = '{act: A_EMIT_ST, cond: C_GOTO,     emit: 1'b1, target: ST_IDLE};
            default:    uw = '{act: A_IDLE,    cond: C_GOTO,     emit: 1'b0, target: ST_IDLE};
        endcase
        return uw;
    endfunction

    // Entry step of each request's routine.
    function automatic t_step dispatch(input t_req req);
        t_step step;
        unique case (req)
            REQ_INIT:       step = ST_INIT_A;
            REQ_ALLOC_PAGE: step = ST_P_POP;
            REQ_FREE_PAGE:  step = ST_P_FREE;
            REQ_ALLOC_SUP:  step = ST_S_POP;
            REQ_FREE_SUP:   step = ST_S_FREE;
            default:        step = ST_EMIT_ST;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

[sv/tppa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tppa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32768,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/tppa_seq.sv]
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none

module tppa_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tppa_pkg::t_req i_req,
    input  wire logic          i_flag,
    input  wire logic          i_out_free,
    output tppa_pkg::t_uctl    o_ctl
);

    tppa_pkg::t_step  r_pc;
    tppa_pkg::t_step  n_pc;
    tppa_pkg::t_uword w_uw;
    logic             w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tppa_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        w_uw = tppa_pkg::ucode(r_pc);
        // A step that loads the result waits for the output register.
        w_go = !w_uw.emit || i_out_free;
        n_pc = r_pc;
        if (w_go) begin
            unique case (w_uw.cond)
                tppa_pkg::C_NEXT:     n_pc = r_pc + 1'b1;
                tppa_pkg::C_GOTO:     n_pc = w_uw.target;
                tppa_pkg::C_IF:       n_pc = i_flag ? w_uw.target : r_pc + 1'b1;
                tppa_pkg::C_LOOP:     n_pc = i_flag ? r_pc + 1'b1 : r_pc;
                tppa_pkg::C_DISPATCH: n_pc = i_start ? tppa_pkg::dispatch(i_req) : r_pc;
                default:              n_pc = tppa_pkg::ST_IDLE;
            endcase
        end
        o_ctl.act = w_uw.act;
        o_ctl.go  = w_go;
    end

endmodule

`default_nettype wire

[sv/two_pool_page_allocator_top.sv]
// Two-pool page allocator: 4 KiB page stack and 2 MiB superpage stack.
// Init empties both pools, then pushes the pages and superpages of the range;
//   the single write port of each stack RAM takes one push a cycle.
// Throughput: one word in flight; the next is taken once the routine ends.
// Reset (synchronous, active low): pools empty, no region, registers to defaults.
`default_nettype none
`include "two_pool_page_allocator_top_macros.svh"

module two_pool_page_allocator_top #(
    parameter int unsigned PAGE_STACK_DEPTH  = tppa_pkg::PAGE_STACK_DEPTH_DEF,
    parameter int unsigned SUPER_STACK_DEPTH = tppa_pkg::SUPER_STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] address
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] alloc_address, [33:32] status, rest zero
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW  = tppa_pkg::ADDR_W;
    localparam int PS  = tppa_pkg::PAGE_SHIFT;
    localparam int SS  = tppa_pkg::SUPER_SHIFT;
    localparam int PNW = tppa_pkg::PN_W;
    localparam int SNW = tppa_pkg::SN_W;
    localparam int PCW = $clog2(PAGE_STACK_DEPTH + 1);
    localparam int SCW = $clog2(SUPER_STACK_DEPTH + 1);
    localparam int PAW = (PAGE_STACK_DEPTH > 1) ? $clog2(PAGE_STACK_DEPTH) : 1;
    localparam int SAW = (SUPER_STACK_DEPTH > 1) ? $clog2(SUPER_STACK_DEPTH) : 1;

    // ---------------------------------------------------------------- registers
    logic [AW-1:0]   r_kernel_end;
    logic [AW-1:0]   r_phys_stop;

    logic [PCW-1:0]  r_page_count,  n_page_count;
    logic [SCW-1:0]  r_super_count, n_super_count;
    logic [SNW-1:0]  r_rlo, n_rlo;          // superpage region, as superpage numbers
    logic [SNW-1:0]  r_rhi, n_rhi;
    tppa_pkg::t_status r_status, n_status;
    logic [AW-1:0]   r_addr, n_addr;
    logic [PNW:0]    r_start_pn, n_start_pn; // rounded kernel end, may reach 2^20
    logic [AW-1:0]   r_work, n_work;         // range size, then reserve base
    logic [PNW:0]    r_ptr, n_ptr;           // walk pointer for init runs
    logic [PNW:0]    r_end, n_end;

    logic              r_out_valid, n_out_valid;
    logic [AW-1:0]     r_out_addr, n_out_addr;
    tppa_pkg::t_status r_out_status, n_out_status;

    // ---------------------------------------------------------------- control
    tppa_pkg::t_uctl w_ctl;
    logic            w_flag;
    logic            w_accept;
    logic            w_out_free;

    logic            w_p_we, w_p_re, w_s_we, w_s_re;
    logic [PAW-1:0]  w_p_waddr, w_p_raddr;
    logic [SAW-1:0]  w_s_waddr, w_s_raddr;
    logic [PNW-1:0]  w_p_wdata, w_p_rdata;
    logic [SNW-1:0]  w_s_wdata, w_s_rdata;

    // ---------------------------------------------------------------- datapath terms
    logic [PCW-1:0]  w_pcnt_dec;
    logic [SCW-1:0]  w_scnt_dec;
    logic            w_p_full, w_s_full;
    logic            w_run_done;
    logic            w_start_ge;
    logic [AW-1:0]   w_diff;
    logic [AW-1:0]   w_base;
    logic [SNW:0]    w_slo_sn;
    logic [SNW-1:0]  w_stop_sn;
    logic            w_no_region;
    logic [PNW:0]    w_stop_pn;
    logic            w_pfree_ok, w_sfree_ok;

    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;
    assign s_tready   = (w_ctl.act == tppa_pkg::A_IDLE);

    tppa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_req      (s_tuser),
        .i_flag     (w_flag),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl)
    );

    tppa_ram #(.WIDTH(PNW), .DEPTH(PAGE_STACK_DEPTH)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_re    (w_p_re),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    tppa_ram #(.WIDTH(SNW), .DEPTH(SUPER_STACK_DEPTH)) u_super_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_re    (w_s_re),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    always_comb begin
        w_pcnt_dec = r_page_count - 1'b1;
        w_scnt_dec = r_super_count - 1'b1;
        w_p_full   = r_page_count >= PCW'(PAGE_STACK_DEPTH);
        w_s_full   = r_super_count >= SCW'(SUPER_STACK_DEPTH);
        w_run_done = r_ptr >= r_end;

        // Init range: rounded kernel end against phys_stop, then its size.
        w_start_ge = {r_start_pn, {PS{1'b0}}} >= {1'b0, r_phys_stop};
        w_diff     = r_phys_stop - {r_start_pn[PNW-1:0], {PS{1'b0}}};
        // Base of the superpage reserve: stop less a quarter, superpage granular.
        w_base     = r_phys_stop
                   - {{tppa_pkg::RESERVE_SHIFT{1'b0}},
                      r_work[AW-1:SS+tppa_pkg::RESERVE_SHIFT], {SS{1'b0}}};
        // Region low rounded up to a superpage; may reach the top of the space.
        w_slo_sn   = {1'b0, r_work[AW-1:SS]} + {{SNW{1'b0}}, |r_work[SS-1:0]};
        w_stop_sn  = r_phys_stop[AW-1:SS];
        w_no_region = {1'b0, w_stop_sn} <= w_slo_sn;
        w_stop_pn  = {1'b0, r_phys_stop[AW-1:PS]};

        w_pfree_ok = (r_addr[PS-1:0] == '0) && (r_addr >= r_kernel_end)
                  && (r_addr < r_phys_stop);
        w_sfree_ok = (r_addr[SS-1:0] == '0) && (r_rlo != '0)
                  && (r_addr[AW-1:SS] >= r_rlo) && (r_addr[AW-1:SS] < r_rhi);
    end

    // One action per control word; nothing moves while a result step waits.
    always_comb begin
        n_page_count  = r_page_count;
        n_super_count = r_super_count;
        n_rlo         = r_rlo;
        n_rhi         = r_rhi;
        n_status      = r_status;
        n_addr        = r_addr;
        n_start_pn    = r_start_pn;
        n_work        = r_work;
        n_ptr         = r_ptr;
        n_end         = r_end;
        n_out_valid   = r_out_valid && !m_tready;
        n_out_addr    = r_out_addr;
        n_out_status  = r_out_status;
        w_flag        = 1'b0;
        w_p_we        = 1'b0;
        w_p_re        = 1'b0;
        w_s_we        = 1'b0;
        w_s_re        = 1'b0;
        w_p_waddr     = r_page_count[PAW-1:0];
        w_p_raddr     = w_pcnt_dec[PAW-1:0];
        w_s_waddr     = r_super_count[SAW-1:0];
        w_s_raddr     = w_scnt_dec[SAW-1:0];
        w_p_wdata     = r_ptr[PNW-1:0];
        w_s_wdata     = r_ptr[SNW-1:0];

        if (w_ctl.go) begin
            unique case (w_ctl.act)
                tppa_pkg::A_IDLE: begin
                    if (w_accept) begin
                        n_addr   = s_tdata;
                        n_status = tppa_pkg::STAT_OK;
                    end
                end
                tppa_pkg::A_POP_P: begin
                    w_flag = (r_page_count == '0);
                    if (w_flag) begin
                        n_status = tppa_pkg::STAT_EMPTY;
                    end else begin
                        n_page_count = w_pcnt_dec;
                        w_p_re       = 1'b1;
                    end
                end
                tppa_pkg::A_EMIT_P: begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = {w_p_rdata, {PS{1'b0}}};
                    n_out_status = tppa_pkg::STAT_OK;
                end
                tppa_pkg::A_POP_S: begin
                    w_flag = (r_super_count == '0);
                    if (w_flag) begin
                        n_status = tppa_pkg::STAT_EMPTY;
                    end else begin
                        n_super_count = w_scnt_dec;
                        w_s_re        = 1'b1;
                    end
                end
                tppa_pkg::A_EMIT_S: begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = {w_s_rdata, {SS{1'b0}}};
                    n_out_status = tppa_pkg::STAT_OK;
                end
                tppa_pkg::A_FREE_P: begin
                    n_out_valid = 1'b1;
                    n_out_addr  = '0;
                    if (!w_pfree_ok) begin
                        n_out_status = tppa_pkg::STAT_BADFREE;
                    end else if (w_p_full) begin
                        n_out_status = tppa_pkg::STAT_OVERFLOW;
                    end else begin
                        w_p_we       = 1'b1;
                        w_p_wdata    = r_addr[AW-1:PS];
                        n_page_count = r_page_count + 1'b1;
                        n_out_status = tppa_pkg::STAT_OK;
                    end
                end
                tppa_pkg::A_FREE_S: begin
                    n_out_valid = 1'b1;
                    n_out_addr  = '0;
                    if (!w_sfree_ok) begin
                        n_out_status = tppa_pkg::STAT_BADFREE;
                    end else if (w_s_full) begin
                        n_out_status = tppa_pkg::STAT_OVERFLOW;
                    end else begin
                        w_s_we        = 1'b1;
                        w_s_wdata     = r_addr[AW-1:SS];
                        n_super_count = r_super_count + 1'b1;
                        n_out_status  = tppa_pkg::STAT_OK;
                    end
                end
                tppa_pkg::A_INIT_A: begin
                    // Empty both pools, drop the region, round kernel end up.
                    n_page_count  = '0;
                    n_super_count = '0;
                    n_rlo         = '0;
                    n_rhi         = '0;
                    n_start_pn    = {1'b0, r_kernel_end[AW-1:PS]}
                                  + {{PNW{1'b0}}, |r_kernel_end[PS-1:0]};
                end
                tppa_pkg::A_INIT_B: begin
                    w_flag = w_start_ge;
                    n_work = w_diff;
                end
                tppa_pkg::A_INIT_C: begin
                    n_work = w_base;
                end
                tppa_pkg::A_INIT_D: begin
                    w_flag = w_no_region;
                    n_ptr  = r_start_pn;
                    if (w_no_region) begin
                        n_end = w_stop_pn;
                    end else begin
                        n_rlo = w_slo_sn[SNW-1:0];
                        n_rhi = w_stop_sn;
                        n_end = {1'b0, w_slo_sn[SNW-1:0], {(SS-PS){1'b0}}};
                    end
                end
                tppa_pkg::A_PUSH_P: begin
                    // Advance one page a cycle; a full stack ends the run.
                    w_flag = w_run_done || w_p_full;
                    if (!w_run_done) begin
                        if (w_p_full) begin
                            n_status = tppa_pkg::STAT_OVERFLOW;
                        end else begin
                            w_p_we       = 1'b1;
                            n_page_count = r_page_count + 1'b1;
                            n_ptr        = r_ptr + 1'b1;
                        end
                    end
                end
                tppa_pkg::A_SET_SUP: begin
                    n_ptr = {{(PNW+1-SNW){1'b0}}, r_rlo};
                    n_end = {{(PNW+1-SNW){1'b0}}, r_rhi};
                end
                tppa_pkg::A_PUSH_S: begin
                    w_flag = w_run_done || w_s_full;
                    if (!w_run_done) begin
                        if (w_s_full) begin
                            n_status = tppa_pkg::STAT_OVERFLOW;
                        end else begin
                            w_s_we        = 1'b1;
                            n_super_count = r_super_count + 1'b1;
                            n_ptr         = r_ptr + 1'b1;
                        end
                    end
                end
                tppa_pkg::A_SET_HI: begin
                    n_ptr = {1'b0, r_rhi, {(SS-PS){1'b0}}};
                    n_end = w_stop_pn;
                end
                tppa_pkg::A_EMIT_ST: begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = r_status;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end  <= tppa_pkg::KERNEL_END_RST;
            r_phys_stop   <= tppa_pkg::PHYS_STOP_RST;
            r_page_count  <= '0;
            r_super_count <= '0;
            r_rlo         <= '0;
            r_rhi         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2]) begin
                    r_phys_stop <= pwdata;
                end else begin
                    r_kernel_end <= pwdata;
                end
            end
            r_page_count  <= n_page_count;
            r_super_count <= n_super_count;
            r_rlo         <= n_rlo;
            r_rhi         <= n_rhi;
            r_out_valid   <= n_out_valid;
        end
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_start_pn   <= n_start_pn;
        r_work       <= n_work;
        r_ptr        <= n_ptr;
        r_end        <= n_end;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(tppa_pkg::TDATA_OUT_W-AW-tppa_pkg::STAT_W){1'b0}},
                       r_out_status, r_out_addr};
    assign prdata   = paddr[2] ? r_phys_stop : r_kernel_end;
    assign pready   = 1'b1;

    // ---------------------------------------------------------------- checks
    `TPPA_ASSERT_IMP(a_page_push_room, w_p_we, r_page_count < PCW'(PAGE_STACK_DEPTH))
    `TPPA_ASSERT_IMP(a_super_push_room, w_s_we, r_super_count < SCW'(SUPER_STACK_DEPTH))
    `TPPA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
